// File: hdl/tac_pkg.sv
`default_nettype none
package tac_pkg;

   // converter width and derived datapath widths
   localparam int ADC_BITS  = 10;
   localparam int DEN_W     = ADC_BITS + 1;
   localparam int NUM_W     = 16 + ADC_BITS;
   localparam int ADC_FULL  = 1 << ADC_BITS;
   localparam int RT_BITS   = 16;
   localparam int LOG_STEPS = 16;
   localparam int Q_BITS    = 16;
   localparam int D_W       = 56;
   localparam int QR_W      = 67;

   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam int          KELVIN_CENTI = 27315;
   localparam int          CLIP_HI      = KELVIN_CENTI + 12800;
   localparam int          CLIP_LO      = 12900;
   localparam logic [12:0] RECIP100     = 13'd5243;
   localparam int          RECIP_SH     = 19;

   localparam logic signed [D_W-1:0] BIG_LIM  = 56'sd429496729600;
   localparam logic [QR_W-1:0]       DIVIDEND = 67'd28147497671065600;

   // stage map
   localparam int ST_IN    = 0;
   localparam int ST_RD0   = 1;
   localparam int ST_LOG0  = ST_RD0 + RT_BITS;
   localparam int ST_SQ0   = ST_LOG0 + 1;
   localparam int ST_LN    = ST_SQ0 + LOG_STEPS;
   localparam int ST_L2    = ST_LN + 1;
   localparam int ST_L3    = ST_L2 + 1;
   localparam int ST_PROD  = ST_L3 + 1;
   localparam int ST_SUM   = ST_PROD + 1;
   localparam int ST_CLS   = ST_SUM + 1;
   localparam int ST_QD0   = ST_CLS + 1;
   localparam int ST_SEL   = ST_QD0 + Q_BITS;
   localparam int ST_MUL   = ST_SEL + 1;
   localparam int ST_OUT   = ST_MUL + 1;
   localparam int N_STAGES = ST_OUT + 1;

   // register map
   localparam int          ADDR_W     = 6;
   localparam logic [2:0]  REG_SUPPLY = 3'd0;
   localparam logic [2:0]  REG_R1     = 3'd1;
   localparam logic [2:0]  REG_COEF_A = 3'd2;
   localparam logic [2:0]  REG_COEF_B = 3'd3;
   localparam logic [2:0]  REG_COEF_C = 3'd4;

   typedef enum logic [1:0] {
      OUT_POS,
      OUT_NEG,
      OUT_MAX,
      OUT_MIN
   } sel_type;

   typedef struct packed {
      logic                  bad;
      logic                  rt_sat;
      logic [NUM_W-1:0]      rem;
      logic [DEN_W-1:0]      den;
      logic [RT_BITS-1:0]    q;
      logic [3:0]            k;
      logic [30:0]           m;
      logic [LOG_STEPS-1:0]  frac;
      logic [19:0]           l;
      logic [23:0]           l2;
      logic [27:0]           l3;
      logic signed [D_W-1:0] pb;
      logic signed [D_W-1:0] pch;
      logic signed [D_W-1:0] pcl;
      logic signed [D_W-1:0] d;
      logic                  dzero;
      logic                  dneg;
      logic                  big;
      logic [QR_W-1:0]       rem2;
      logic [Q_BITS-1:0]     q2;
      sel_type               sel;
      logic                  flag;
      logic [13:0]           x;
      logic [26:0]           xp;
      logic [7:0]            t;
   } pipe_type;

endpackage
`default_nettype wire

// File: hdl/thermistor_adc_to_celsius.sv
// Throughput: one code word per cycle while rsp_tready accepts results; every stage holds its word while the
// stage after it is full and stalled, so bubbles are squeezed out.
// Reset (synchronous, active high): all stages empty, registers back to
// supply 5, resistor 10000 ohms and all three coefficients zero.
`default_nettype none
module thermistor_adc_to_celsius (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [15:0]                req_tdata,   // [9:0] adc_code
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [15:0]                rsp_tdata,   // [7:0] temp_celsius, [8] out_of_range
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [tac_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]                csr_pwdata,
   output      logic [63:0]                csr_prdata,
   output      logic                       csr_pready
);
   import tac_pkg::*;

   // ---------------- configuration registers ----------------
   logic [15:0] supply_ff, r1_ff;
   logic [39:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= 16'd5;
         r1_ff     <= 16'd10000;
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_SUPPLY: supply_ff <= csr_pwdata[15:0];
            REG_R1:     r1_ff     <= csr_pwdata[15:0];
            REG_COEF_A: coef_a_ff <= csr_pwdata[39:0];
            REG_COEF_B: coef_b_ff <= csr_pwdata[39:0];
            REG_COEF_C: coef_c_ff <= csr_pwdata[39:0];
            default: ;   // drop writes beyond the map
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SUPPLY: csr_prdata = {48'b0, supply_ff};
         REG_R1:     csr_prdata = {48'b0, r1_ff};
         REG_COEF_A: csr_prdata = {24'b0, coef_a_ff};
         REG_COEF_B: csr_prdata = {24'b0, coef_b_ff};
         REG_COEF_C: csr_prdata = {24'b0, coef_c_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline ----------------
   pipe_type            pipe_ff [N_STAGES];
   pipe_type            pipe_in [N_STAGES];
   logic [N_STAGES-1:0] v_ff;
   logic [N_STAGES-1:0] adv;

   // a stage may load when it is empty or its word moves on
   always_comb begin
      adv[N_STAGES-1] = !v_ff[N_STAGES-1] || rsp_tready;
      for (int i = N_STAGES-2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[N_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < N_STAGES; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_STAGES; i++) begin
         if (adv[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // per-stage work
   always_comb begin
      pipe_type                cur;
      pipe_type                nx;
      logic [ADC_BITS-1:0]     code;
      logic [NUM_W:0]          rd_sh;
      logic [RT_BITS-1:0]      rt;
      logic [3:0]              k;
      logic [4:0]              sh;
      logic [61:0]             sq;
      logic [31:0]             msq;
      logic [51:0]             lnp;
      logic [39:0]             l2p;
      logic [43:0]             l3p;
      logic signed [60:0]      pb_w;
      logic signed [52:0]      pch_w;
      logic signed [56:0]      pcl_w;
      logic [QR_W-1:0]         qd_sh;
      logic [15:0]             mm;
      logic [7:0]              qv;
      code = req_tdata[ADC_BITS-1:0];
      for (int i = 0; i < N_STAGES; i++) begin
         cur   = '0;
         rd_sh = '0;
         rt    = '0;
         k     = '0;
         sh    = '0;
         sq    = '0;
         msq   = '0;
         lnp   = '0;
         l2p   = '0;
         l3p   = '0;
         pb_w  = '0;
         pch_w = '0;
         pcl_w = '0;
         qd_sh = '0;
         mm    = '0;
         qv    = '0;
         if (i > 0) begin
            cur = pipe_ff[i-1];
         end
         nx = cur;
         if (i == ST_IN) begin
            // R1*S*code / (S*(full-code)) reduces exactly to R1*code/(full-code)
            nx     = '0;
            nx.bad = (supply_ff == 16'd0);
            nx.rem = r1_ff * code;
            nx.den = DEN_W'(ADC_FULL) - {1'b0, code};
         end else if (i >= ST_RD0 && i < ST_LOG0) begin
            // restoring division, one quotient bit per stage
            if (i == ST_RD0) begin
               nx.rt_sat = ({1'b0, cur.rem} >= {cur.den, 16'b0});
            end
            rd_sh = {{(NUM_W+1-DEN_W){1'b0}}, cur.den} << (RT_BITS-1-(i-ST_RD0));
            if ({1'b0, cur.rem} >= rd_sh) begin
               nx.rem = cur.rem - rd_sh[NUM_W-1:0];
               nx.q[RT_BITS-1-(i-ST_RD0)] = 1'b1;
            end
         end else if (i == ST_LOG0) begin
            // normalize resistance into Q1.30
            rt = cur.rt_sat ? '1 : cur.q;
            nx.bad = cur.bad || (rt == '0);
            for (int j = 0; j < RT_BITS; j++) begin
               if (rt[j]) begin
                  k = 4'(j);
               end
            end
            sh      = 5'd30 - {1'b0, k};
            nx.k    = k;
            nx.m    = 31'(rt) << sh;
            nx.frac = '0;
         end else if (i >= ST_SQ0 && i < ST_LN) begin
            // square and renormalize, one fraction bit per stage
            sq      = cur.m * cur.m;
            msq     = sq[61:30];
            nx.frac = {cur.frac[LOG_STEPS-2:0], msq[31]};
            nx.m    = msq[31] ? msq[31:1] : msq[30:0];
         end else if (i == ST_LN) begin
            lnp  = {cur.k, cur.frac} * LN2_Q32;
            nx.l = lnp[51:32];
         end else if (i == ST_L2) begin
            l2p   = cur.l * cur.l;
            nx.l2 = l2p[39:16];
         end else if (i == ST_L3) begin
            l3p   = cur.l2 * cur.l;
            nx.l3 = l3p[43:16];
         end else if (i == ST_PROD) begin
            pb_w   = $signed(coef_b_ff) * $signed({1'b0, cur.l});
            pch_w  = $signed(coef_c_ff) * $signed({1'b0, cur.l3[27:16]});
            pcl_w  = $signed(coef_c_ff) * $signed({1'b0, cur.l3[15:0]});
            nx.pb  = D_W'(pb_w >>> 16);
            nx.pch = D_W'(pch_w);
            nx.pcl = D_W'(pcl_w >>> 16);
         end else if (i == ST_SUM) begin
            nx.d = D_W'($signed(coef_a_ff)) + cur.pb + cur.pch + cur.pcl;
         end else if (i == ST_CLS) begin
            nx.dzero = (cur.d == '0);
            nx.dneg  = cur.d[D_W-1];
            nx.big   = !cur.d[D_W-1] && (cur.d <= BIG_LIM);
            nx.rem2  = DIVIDEND;
            nx.q2    = '0;
         end else if (i >= ST_QD0 && i < ST_SEL) begin
            qd_sh = {{(QR_W-D_W){1'b0}}, cur.d} << (Q_BITS-1-(i-ST_QD0));
            if (cur.rem2 >= qd_sh) begin
               nx.rem2 = cur.rem2 - qd_sh;
               nx.q2[Q_BITS-1-(i-ST_QD0)] = 1'b1;
            end
         end else if (i == ST_SEL) begin
            nx.flag = cur.rt_sat;
            nx.x    = '0;
            nx.sel  = OUT_MIN;
            mm      = 16'(KELVIN_CENTI) - cur.q2 - 16'(cur.rem2 != '0);
            priority if (cur.bad) begin
               nx.sel  = OUT_MIN;
               nx.flag = 1'b1;
            end else if (cur.dzero) begin
               nx.sel  = OUT_MAX;
               nx.flag = 1'b1;
            end else if (cur.dneg) begin
               nx.sel  = OUT_MIN;
               nx.flag = 1'b1;
            end else if (cur.big || cur.q2 >= 16'(CLIP_HI)) begin
               nx.sel  = OUT_MAX;
               nx.flag = 1'b1;
            end else if (cur.q2 >= 16'(KELVIN_CENTI)) begin
               nx.sel = OUT_POS;
               nx.x   = 14'(cur.q2 - 16'(KELVIN_CENTI));
            end else if (mm >= 16'(CLIP_LO)) begin
               nx.sel  = OUT_MIN;
               nx.flag = 1'b1;
            end else begin
               nx.sel = OUT_NEG;
               nx.x   = mm[13:0];
            end
         end else if (i == ST_MUL) begin
            // divide by 100 through the reciprocal
            nx.xp = cur.x * RECIP100;
         end else begin
            qv = cur.xp[RECIP_SH+7:RECIP_SH];
            unique case (cur.sel)
               OUT_POS: nx.t = qv;
               OUT_NEG: nx.t = 8'd0 - qv;
               OUT_MAX: nx.t = 8'h7F;
               OUT_MIN: nx.t = 8'h80;
               default: nx.t = 8'h80;
            endcase
         end
         pipe_in[i] = nx;
      end
   end

   assign rsp_tdata = {7'b0, pipe_ff[ST_OUT].flag, pipe_ff[ST_OUT].t};

   // ---------------- assertions ----------------
   // an empty output stage means nothing can block the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   // words in flight change only by accepts and deliveries
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(v_ff) ==
         $past($countones(v_ff)) + int'($past(req_tvalid && req_tready))
         - int'($past(rsp_tvalid && rsp_tready))))
      else $error("word lost or duplicated in pipeline");

   // a clipped resistance must be flagged at the output
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pipe_ff[ST_OUT].rt_sat) |-> rsp_tdata[8])
      else $error("saturated resistance not flagged");

endmodule
`default_nettype wire
